// File: hdl/esp_pkg.sv
// Shared types and constants for the event slot pool.
`default_nettype none

package esp_pkg;

   localparam int FUNC_W   = 3;
   localparam int SLOT_W   = 4;
   localparam int STREAM_W = 4;
   localparam int WORD_W   = 32;
   localparam int REFS_W   = 2;

   // Command codes
   typedef enum logic [FUNC_W-1:0] {
      FN_ACQUIRE  = 3'd0,
      FN_RELEASE  = 3'd1,
      FN_RECORD   = 3'd2,
      FN_NOTIFY   = 3'd3,
      FN_SIGNAL   = 3'd4,
      FN_COMPLETE = 3'd5
   } func_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_FREE    = 3'd2,
      ST_PENDING = 3'd3,
      ST_WRONG   = 3'd4,
      ST_NONE    = 3'd5,
      ST_STREAM  = 3'd6,
      ST_IGNORED = 3'd7
   } status_type;

   // Slot lifecycle
   typedef enum logic [2:0] {
      EV_POOLED    = 3'd0,
      EV_ACQUIRED  = 3'd1,
      EV_RECORDED  = 3'd2,
      EV_SIGNALED  = 3'd3,
      EV_PENDING   = 3'd4
   } life_type;

   // Everything held for one slot
   typedef struct packed {
      life_type            life;
      logic [WORD_W-1:0]   ident;
      logic [WORD_W-1:0]   signals;
      logic [REFS_W-1:0]   refs;
      logic                cb;
   } slot_rec_type;

   // Free stack status seen by the command logic
   typedef struct packed {
      logic empty;
      logic full;
   } stack_stat_type;

endpackage

`default_nettype wire

// File: hdl/esp_free_stack.sv
// LIFO of free slot numbers with push and pop in the same clock as the update.
`default_nettype none

module esp_free_stack
   import esp_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       pop,
   input  wire logic                       push,
   input  wire logic [$clog2(SLOTS)-1:0]   push_slot,
   output logic [$clog2(SLOTS)-1:0]        top_slot,
   output stack_stat_type                  stat
);

   localparam int IdxW = $clog2(SLOTS);
   localparam int TopW = $clog2(SLOTS + 1);

   logic [IdxW-1:0] stack_ff [SLOTS];
   logic [TopW-1:0] top_ff;
   logic [TopW-1:0] top_m1;

   // Entry below the top pointer is the next slot handed out
   assign top_m1     = top_ff - TopW'(1);
   assign top_slot   = stack_ff[top_m1[IdxW-1:0]];
   assign stat.empty = (top_ff == '0);
   assign stat.full  = (top_ff >= TopW'(SLOTS));

   // Stack storage and pointer; reset puts every slot on the stack
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            stack_ff[i] <= IdxW'(i);
         end
         top_ff <= TopW'(SLOTS);
      end else if (pop) begin
         top_ff <= top_m1;
      end else if (push) begin
         stack_ff[top_ff[IdxW-1:0]] <= push_slot;
         top_ff <= top_ff + TopW'(1);
      end
   end

endmodule

`default_nettype wire

// File: hdl/esp_slot_file.sv
// Per-slot records: one read port, one write port.
`default_nettype none

module esp_slot_file
   import esp_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [$clog2(SLOTS)-1:0]   rd_idx,
   output slot_rec_type                    rd_rec,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(SLOTS)-1:0]   wr_idx,
   input  wire slot_rec_type               wr_rec
);

   slot_rec_type rec_ff [SLOTS];

   assign rd_rec = rec_ff[rd_idx];

   // Records clear to pooled, zero id and zero count
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            rec_ff[i] <= '{EV_POOLED, '0, '0, '0, 1'b0};
         end
      end else if (wr_en) begin
         rec_ff[wr_idx] <= wr_rec;
      end
   end

endmodule

`default_nettype wire

// File: hdl/event_slot_pool_refcount.sv
// Top level of the event slot pool with reference counting.
//
// Commands enter on start/req_func/req_slot/req_stream. A command transfers
// at a rising edge where start is high and busy is low; busy is high only
// while reset is asserted, so one command can transfer every cycle.
// Each command gives exactly one result, shown for one cycle with rsp_valid
// high: status, the slot acquired or addressed, and that slot's lifecycle,
// id and signal count after the command.
// The command is registered at its transfer edge; the slot record and free
// stack are read, updated and written at the next edge together with the
// result register, which drives rsp_valid. Throughput is one command per
// cycle, set by the single read-modify-write of the slot file and the free
// stack top.
// Reset (synchronous) returns every slot to the pool, fills the free stack
// with all slots, zeroes the id counter and drops any result in flight.
// The receiver cannot hold results off; each result is taken in its cycle.
`default_nettype none

module event_slot_pool_refcount
   import esp_pkg::*;
#(
   parameter int SLOTS   = 16,
   parameter int STREAMS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [FUNC_W-1:0]     req_func,
   input  wire logic [SLOT_W-1:0]     req_slot,
   input  wire logic [STREAM_W-1:0]   req_stream,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_status,
   output logic [SLOT_W-1:0]          rsp_slot_out,
   output logic [2:0]                 rsp_slot_state,
   output logic [WORD_W-1:0]          rsp_event_ident,
   output logic [WORD_W-1:0]          rsp_signal_count
);

   localparam int IdxW = $clog2(SLOTS);

   // Command register
   logic                  req_valid_ff;
   func_type              func_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [STREAM_W-1:0]   stream_ff;
   logic [WORD_W-1:0]     id_ff;

   // Result register
   logic                  rsp_valid_ff;
   status_type            status_ff;
   logic [SLOT_W-1:0]     slot_out_ff;
   life_type              state_ff;
   logic [WORD_W-1:0]     ident_ff;
   logic [WORD_W-1:0]     count_ff;

   // Command logic
   logic                  accept;
   logic                  in_range;
   logic [IdxW-1:0]       top_slot;
   stack_stat_type        stack_stat;
   logic [IdxW-1:0]       rd_idx;
   slot_rec_type          cur;
   slot_rec_type          nxt;
   slot_rec_type          shown;
   status_type            status_in;
   logic [SLOT_W-1:0]     slot_out_in;
   logic                  show;
   logic                  wr_en;
   logic                  push;
   logic                  pop;

   assign busy   = reset;
   assign accept = start && !busy;

   // Acquire looks at the slot on top of the free stack, others at the named slot
   assign in_range = ({1'b0, slot_ff} < (SLOT_W+1)'(SLOTS));
   assign rd_idx   = (func_ff == FN_ACQUIRE) ? top_slot : slot_ff[IdxW-1:0];

   esp_free_stack #(
      .SLOTS (SLOTS)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .pop       (req_valid_ff && pop),
      .push      (req_valid_ff && push),
      .push_slot (slot_ff[IdxW-1:0]),
      .top_slot  (top_slot),
      .stat      (stack_stat)
   );

   esp_slot_file #(
      .SLOTS (SLOTS)
   ) u_slots (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (rd_idx),
      .rd_rec (cur),
      .wr_en  (req_valid_ff && wr_en),
      .wr_idx (rd_idx),
      .wr_rec (nxt)
   );

   // Decode the command against the slot's current record
   always_comb begin
      status_in   = ST_IGNORED;
      nxt         = cur;
      wr_en       = 1'b0;
      push        = 1'b0;
      pop         = 1'b0;
      show        = 1'b1;
      slot_out_in = slot_ff;
      if (func_ff == FN_ACQUIRE) begin
         slot_out_in = SLOT_W'(top_slot);
         if (stack_stat.empty) begin
            status_in   = ST_EMPTY;
            show        = 1'b0;
            slot_out_in = '0;
         end else if (cur.life != EV_POOLED) begin
            status_in = ST_WRONG;
         end else begin
            status_in = ST_OK;
            nxt       = '{EV_ACQUIRED, id_ff + WORD_W'(1), '0, REFS_W'(1), 1'b0};
            wr_en     = 1'b1;
            pop       = 1'b1;
         end
      end else if (!in_range) begin
         status_in = ST_IGNORED;
         show      = 1'b0;
      end else begin
         case (func_ff)
            FN_RELEASE: begin
               if (cur.life == EV_POOLED) begin
                  status_in = ST_FREE;
               end else if (cur.refs > REFS_W'(1) || cur.cb) begin
                  status_in = ST_PENDING;
               end else if (stack_stat.full) begin
                  status_in = ST_WRONG;
               end else begin
                  status_in = ST_OK;
                  nxt       = '{EV_POOLED, '0, '0, '0, cur.cb};
                  wr_en     = 1'b1;
                  push      = 1'b1;
               end
            end
            FN_RECORD: begin
               if (stream_ff == '0 || stream_ff > STREAM_W'(STREAMS)) begin
                  status_in = ST_STREAM;
               end else if (cur.life == EV_POOLED) begin
                  status_in = ST_FREE;
               end else if (cur.life != EV_ACQUIRED && cur.life != EV_SIGNALED) begin
                  status_in = ST_WRONG;
               end else begin
                  status_in   = ST_OK;
                  nxt.signals = cur.signals + WORD_W'(1);
                  nxt.life    = EV_RECORDED;
                  wr_en       = 1'b1;
               end
            end
            FN_NOTIFY: begin
               if (cur.life == EV_POOLED) begin
                  status_in = ST_FREE;
               end else if (cur.life != EV_RECORDED) begin
                  status_in = ST_WRONG;
               end else begin
                  status_in = ST_OK;
                  nxt.refs  = cur.refs + REFS_W'(1);
                  nxt.cb    = 1'b1;
                  nxt.life  = EV_PENDING;
                  wr_en     = 1'b1;
               end
            end
            FN_SIGNAL: begin
               if (cur.life == EV_RECORDED) begin
                  status_in = ST_OK;
                  nxt.life  = EV_SIGNALED;
                  wr_en     = 1'b1;
               end else begin
                  status_in = ST_IGNORED;
               end
            end
            FN_COMPLETE: begin
               if (!cur.cb) begin
                  status_in = ST_NONE;
               end else if (cur.refs <= REFS_W'(1)) begin
                  status_in = ST_WRONG;
               end else begin
                  status_in = ST_OK;
                  nxt.refs  = cur.refs - REFS_W'(1);
                  nxt.cb    = 1'b0;
                  if (cur.life == EV_PENDING) begin
                     nxt.life = EV_SIGNALED;
                  end
                  wr_en = 1'b1;
               end
            end
            default: begin
               status_in = ST_IGNORED;
            end
         endcase
      end
   end

   // Result shows the record as it stands after the command
   assign shown = wr_en ? nxt : cur;

   // Command register and id counter
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         id_ff        <= '0;
      end else begin
         req_valid_ff <= accept;
         if (req_valid_ff && pop) begin
            id_ff <= id_ff + WORD_W'(1);
         end
      end
      if (accept) begin
         func_ff   <= func_type'(req_func);
         slot_ff   <= req_slot;
         stream_ff <= req_stream;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
      if (req_valid_ff) begin
         status_ff   <= status_in;
         slot_out_ff <= slot_out_in;
         state_ff    <= show ? shown.life : EV_POOLED;
         ident_ff    <= show ? shown.ident : '0;
         count_ff    <= show ? shown.signals : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_slot_out     = slot_out_ff;
   assign rsp_slot_state   = state_ff;
   assign rsp_event_ident  = ident_ff;
   assign rsp_signal_count = count_ff;

endmodule

`default_nettype wire

// File: hdl/esp_checker.sv
// Port-level checks for the event slot pool, bound to the top level.
`default_nettype none

module esp_checker
   import esp_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic                  rsp_valid,
   input wire logic [2:0]            rsp_status,
   input wire logic [SLOT_W-1:0]     rsp_slot_out,
   input wire logic [2:0]            rsp_slot_state,
   input wire logic [WORD_W-1:0]     rsp_event_ident,
   input wire logic [WORD_W-1:0]     rsp_signal_count
);

   // Every transfer yields a result
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("command transfer without a result");

   // No result without an earlier transfer
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without a command");

   // An empty pool reports an all-zero slot
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |->
         (rsp_slot_out == '0 && rsp_slot_state == EV_POOLED && rsp_event_ident == '0))
      else $error("pool-empty result carries slot data");

   // A pooled slot never holds an id or a signal count
   a_pooled_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_slot_state == EV_POOLED) |->
         (rsp_event_ident == '0 && rsp_signal_count == '0))
      else $error("pooled slot with id or count");

endmodule

bind event_slot_pool_refcount esp_checker u_esp_checker (.*);

`default_nettype wire

// File: test/event_slot_pool_refcount_mon.sv
// Result predictor and comparator for the event slot pool testbench.
`default_nettype none

module event_slot_pool_refcount_mon
   import esp_pkg::*;
#(
   parameter int SLOTS   = 16,
   parameter int STREAMS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  busy,
   input  wire logic [FUNC_W-1:0]     req_func,
   input  wire logic [SLOT_W-1:0]     req_slot,
   input  wire logic [STREAM_W-1:0]   req_stream,
   input  wire logic                  rsp_valid,
   input  wire logic [2:0]            rsp_status,
   input  wire logic [SLOT_W-1:0]     rsp_slot_out,
   input  wire logic [2:0]            rsp_slot_state,
   input  wire logic [WORD_W-1:0]     rsp_event_ident,
   input  wire logic [WORD_W-1:0]     rsp_signal_count,
   output int                         mismatches,
   output int                         outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   // One predicted result
   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      life_type            life;
      logic [WORD_W-1:0]   ident;
      logic [WORD_W-1:0]   sigs;
   } pool_rsp_type;

   // Predicted pool contents
   life_type            life_q   [16];
   logic [WORD_W-1:0]   ident_q  [16];
   logic [WORD_W-1:0]   sigs_q   [16];
   logic [STREAM_W-1:0] strm_q   [16];
   logic [REFS_W-1:0]   refs_q   [16];
   logic                cb_q     [16];
   logic [SLOT_W-1:0]   stack_q  [16];
   int unsigned         top_q;
   logic [WORD_W-1:0]   id_ctr;

   pool_rsp_type owed_results[$];

   function automatic void clear_pool();
      for (int i = 0; i < 16; i++) begin
         life_q[i]  = EV_POOLED;
         ident_q[i] = '0;
         sigs_q[i]  = '0;
         strm_q[i]  = '0;
         refs_q[i]  = '0;
         cb_q[i]    = 1'b0;
         stack_q[i] = SLOT_W'(i);
      end
      top_q  = SLOTS;
      id_ctr = '0;
   endfunction

   // Slot view after the command; zeros when the slot is not reported
   function automatic pool_rsp_type slot_view(status_type st, logic [SLOT_W-1:0] s, bit shown);
      pool_rsp_type r;
      r = '0;
      r.status = st;
      r.slot   = s;
      if (shown) begin
         r.life  = life_q[s];
         r.ident = ident_q[s];
         r.sigs  = sigs_q[s];
      end
      return r;
   endfunction

   // Apply one command to the predicted pool and queue its result
   function automatic void apply_command(logic [FUNC_W-1:0] f, logic [SLOT_W-1:0] s,
                                         logic [STREAM_W-1:0] strm);
      status_type        st;
      logic [SLOT_W-1:0] idx;
      st = ST_OK;
      if (f == FN_ACQUIRE) begin
         if (top_q == 0) begin
            owed_results.push_back(slot_view(ST_EMPTY, '0, 1'b0));
         end else begin
            idx = stack_q[top_q - 1];
            if (life_q[idx] != EV_POOLED) begin
               owed_results.push_back(slot_view(ST_WRONG, idx, 1'b1));
            end else begin
               top_q        = top_q - 1;
               id_ctr       = id_ctr + 1'b1;
               life_q[idx]  = EV_ACQUIRED;
               ident_q[idx] = id_ctr;
               sigs_q[idx]  = '0;
               strm_q[idx]  = '0;
               refs_q[idx]  = 2'd1;
               cb_q[idx]    = 1'b0;
               owed_results.push_back(slot_view(ST_OK, idx, 1'b1));
            end
         end
         return;
      end
      if (s >= SLOTS) begin
         owed_results.push_back(slot_view(ST_IGNORED, s, 1'b0));
         return;
      end
      case (f)
         FN_RELEASE: begin
            if (life_q[s] == EV_POOLED) st = ST_FREE;
            else if (refs_q[s] > 1 || cb_q[s]) st = ST_PENDING;
            else if (top_q >= SLOTS) st = ST_WRONG;
            else begin
               life_q[s]      = EV_POOLED;
               ident_q[s]     = '0;
               sigs_q[s]      = '0;
               strm_q[s]      = '0;
               refs_q[s]      = '0;
               stack_q[top_q] = s;
               top_q          = top_q + 1;
            end
         end
         FN_RECORD: begin
            if (strm == 0 || strm > STREAMS) st = ST_STREAM;
            else if (life_q[s] == EV_POOLED) st = ST_FREE;
            else if (life_q[s] != EV_ACQUIRED && life_q[s] != EV_SIGNALED) st = ST_WRONG;
            else begin
               sigs_q[s] = sigs_q[s] + 1'b1;
               life_q[s] = EV_RECORDED;
               strm_q[s] = strm;
            end
         end
         FN_NOTIFY: begin
            if (life_q[s] == EV_POOLED) st = ST_FREE;
            else if (life_q[s] != EV_RECORDED) st = ST_WRONG;
            else begin
               refs_q[s] = refs_q[s] + 1'b1;
               cb_q[s]   = 1'b1;
               life_q[s] = EV_PENDING;
            end
         end
         FN_SIGNAL: begin
            if (life_q[s] == EV_RECORDED) life_q[s] = EV_SIGNALED;
            else st = ST_IGNORED;
         end
         FN_COMPLETE: begin
            if (!cb_q[s]) st = ST_NONE;
            else if (refs_q[s] <= 1) st = ST_WRONG;
            else begin
               refs_q[s] = refs_q[s] - 1'b1;
               cb_q[s]   = 1'b0;
               if (life_q[s] == EV_PENDING) life_q[s] = EV_SIGNALED;
            end
         end
         default: st = ST_IGNORED;
      endcase
      owed_results.push_back(slot_view(st, s, 1'b1));
   endfunction

   // Compare results first, then predict the command transferred at this edge
   always @(posedge clock) begin : watch
      pool_rsp_type want;
      if (reset) begin
         clear_pool();
         owed_results.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (owed_results.size() == 0) begin
               $error("unexpected result: status %0d slot %0d", rsp_status, rsp_slot_out);
               mismatches++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_slot_out !== want.slot) begin
                  $error("slot_out: expected %0d, got %0d", want.slot, rsp_slot_out);
                  mismatches++;
               end
               if (rsp_slot_state !== want.life) begin
                  $error("slot_state: expected %0d, got %0d", want.life, rsp_slot_state);
                  mismatches++;
               end
               if (rsp_event_ident !== want.ident) begin
                  $error("event_ident: expected %h, got %h", want.ident, rsp_event_ident);
                  mismatches++;
               end
               if (rsp_signal_count !== want.sigs) begin
                  $error("signal_count: expected %h, got %h", want.sigs, rsp_signal_count);
                  mismatches++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            apply_command(req_func, req_slot, req_stream);
      end
      outstanding = owed_results.size();
   end

endmodule

`default_nettype wire

// File: test/event_slot_pool_refcount_tb.sv
// Top of the event slot pool testbench: command stimulus and final verdict.
`default_nettype none

module event_slot_pool_refcount_tb;
   import esp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS   = 16;
   localparam int STREAMS = 8;
   localparam int RAND_ITEMS = 2000;

   // Function codes outside the defined set
   localparam logic [FUNC_W-1:0] FN_UNDEF_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FN_UNDEF_HI = 3'd7;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  start      = 1'b0;
   logic [FUNC_W-1:0]     req_func   = '0;
   logic [SLOT_W-1:0]     req_slot   = '0;
   logic [STREAM_W-1:0]   req_stream = '0;
   logic                  busy;
   logic                  rsp_valid;
   logic [2:0]            rsp_status;
   logic [SLOT_W-1:0]     rsp_slot_out;
   logic [2:0]            rsp_slot_state;
   logic [WORD_W-1:0]     rsp_event_ident;
   logic [WORD_W-1:0]     rsp_signal_count;
   int                    mismatches;
   int                    outstanding;

   int                    idle_pct = 0;
   int                    cmds_sent = 0;

   event_slot_pool_refcount #(.SLOTS(SLOTS), .STREAMS(STREAMS)) DUT (.*);

   event_slot_pool_refcount_mon #(.SLOTS(SLOTS), .STREAMS(STREAMS)) u_mon (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Issue one command, with random idle cycles ahead of it
   task automatic send_cmd(logic [FUNC_W-1:0] f, logic [SLOT_W-1:0] s,
                           logic [STREAM_W-1:0] strm);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_func   <= f;
      req_slot   <= s;
      req_stream <= strm;
      @(posedge clock);
      while (busy) @(posedge clock);
      cmds_sent++;
      if (cmds_sent < RAND_ITEMS / 3) idle_pct = 22;
      else if (cmds_sent < 2 * RAND_ITEMS / 3) idle_pct = 57;
      else idle_pct = 0;
   endtask

   // Record, signal, callback and release steps on one slot
   task automatic slot_lifecycle();
      logic [SLOT_W-1:0] s;
      s = SLOT_W'($urandom_range(SLOTS - 1));
      send_cmd(FN_RECORD, s, STREAM_W'($urandom_range(STREAMS, 1)));
      if ($urandom_range(1)) send_cmd(FN_SIGNAL, s, STREAM_W'($urandom));
      if ($urandom_range(2) == 0)
         send_cmd(FN_RECORD, s, STREAM_W'($urandom_range(STREAMS, 1)));
      if ($urandom_range(3) != 0) begin
         send_cmd(FN_NOTIFY, s, STREAM_W'($urandom));
         if ($urandom_range(3) == 0) send_cmd(FN_RELEASE, s, STREAM_W'($urandom));
         if ($urandom_range(3) == 0) send_cmd(FN_SIGNAL, s, STREAM_W'($urandom));
         if ($urandom_range(5) != 0) send_cmd(FN_COMPLETE, s, STREAM_W'($urandom));
      end
      if ($urandom_range(9) < 4) send_cmd(FN_RELEASE, s, STREAM_W'($urandom));
   endtask

   // Stimulus
   initial begin
      int pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 22;

      // Directed walk through every command and every error status but ST_EMPTY on the first slot out
      send_cmd(FN_ACQUIRE,  4'd3,  4'd0);
      send_cmd(FN_RELEASE,  4'd0,  4'd0);
      send_cmd(FN_RECORD,   4'd15, 4'd0);
      send_cmd(FN_RECORD,   4'd15, 4'd9);
      send_cmd(FN_RECORD,   4'd0,  4'd1);
      send_cmd(FN_SIGNAL,   4'd15, 4'd0);
      send_cmd(FN_NOTIFY,   4'd15, 4'd0);
      send_cmd(FN_COMPLETE, 4'd15, 4'd0);
      send_cmd(FN_RECORD,   4'd15, 4'd8);
      send_cmd(FN_RECORD,   4'd15, 4'd15);
      send_cmd(FN_RECORD,   4'd15, 4'd3);
      send_cmd(FN_NOTIFY,   4'd15, 4'd0);
      send_cmd(FN_RELEASE,  4'd15, 4'd0);
      send_cmd(FN_RECORD,   4'd15, 4'd1);
      send_cmd(FN_SIGNAL,   4'd15, 4'd0);
      send_cmd(FN_COMPLETE, 4'd15, 4'd0);
      send_cmd(FN_COMPLETE, 4'd15, 4'd0);
      send_cmd(FN_RECORD,   4'd15, 4'd1);
      send_cmd(FN_SIGNAL,   4'd15, 4'd0);
      send_cmd(FN_UNDEF_LO, 4'd15, 4'd0);
      send_cmd(FN_UNDEF_HI, 4'd0,  4'd15);
      send_cmd(FN_NOTIFY,   4'd0,  4'd0);
      send_cmd(FN_RELEASE,  4'd15, 4'd0);
      send_cmd(FN_RELEASE,  4'd15, 4'd0);
      send_cmd(FN_ACQUIRE,  4'd12, 4'd7);

      // Random mix: acquire bursts fill the pool, lifecycles drain it, plus noise
      cmds_sent = 0;
      while (cmds_sent < RAND_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            repeat ($urandom_range(6, 1))
               send_cmd(FN_ACQUIRE, SLOT_W'($urandom), STREAM_W'($urandom));
         end else if (pick < 75) begin
            slot_lifecycle();
         end else begin
            send_cmd(FUNC_W'($urandom), SLOT_W'($urandom), STREAM_W'($urandom));
         end
      end
      start <= 1'b0;

      // Drain outstanding results
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("** event_slot_pool_refcount: PASSED **");
      else
         $display("** event_slot_pool_refcount: FAILED **");
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("** event_slot_pool_refcount: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
